### design/rti_pkg.sv
`default_nettype none
package rti_pkg;

  // table geometry
  localparam int ROM_POINTS = 38;
  localparam int IDX_W      = 6;
  localparam int CODE_W     = 15;
  localparam int DEG_W      = 11;
  localparam int SPAN_W     = 10;
  localparam int DT_W       = 5;
  localparam int PROD_W     = 15;
  localparam int TEMP_W     = 19;

  // control byte bits that must be set: bias, auto-conversion, 50 Hz filter
  localparam logic [7:0] CTRL_MASK = 8'hC1;

  // bus transfer outcome codes, the spare code counts as a timeout
  localparam logic [1:0] BUS_OK      = 2'd0;
  localparam logic [1:0] BUS_BUSY    = 2'd1;
  localparam logic [1:0] BUS_TIMEOUT = 2'd2;
  localparam logic [1:0] BUS_SPARE   = 2'd3;

  // result status codes
  localparam logic [2:0] STAT_OK      = 3'd0;
  localparam logic [2:0] STAT_BUSY    = 3'd1;
  localparam logic [2:0] STAT_TIMEOUT = 3'd2;
  localparam logic [2:0] STAT_HWERR   = 3'd3;
  localparam logic [2:0] STAT_SHORT   = 3'd4;
  localparam logic [2:0] STAT_OPEN    = 3'd5;

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CODE_W-1:0]        code_t;
  typedef logic signed [DEG_W-1:0]  deg_t;
  typedef logic [TEMP_W-1:0]        temp_t;

  // converter code of each table point
  function automatic code_t rom_code(input idx_t i);
    code_t c;
    unique case (i)
      6'd0:  c = 15'd7227;
      6'd1:  c = 15'd7550;
      6'd2:  c = 15'd7871;
      6'd3:  c = 15'd8192;
      6'd4:  c = 15'd8512;
      6'd5:  c = 15'd8830;
      6'd6:  c = 15'd9148;
      6'd7:  c = 15'd9465;
      6'd8:  c = 15'd9781;
      6'd9:  c = 15'd10096;
      6'd10: c = 15'd10410;
      6'd11: c = 15'd10723;
      6'd12: c = 15'd11035;
      6'd13: c = 15'd11346;
      6'd14: c = 15'd11657;
      6'd15: c = 15'd11966;
      6'd16: c = 15'd12274;
      6'd17: c = 15'd12582;
      6'd18: c = 15'd12888;
      6'd19: c = 15'd13194;
      6'd20: c = 15'd13498;
      6'd21: c = 15'd13802;
      6'd22: c = 15'd14104;
      6'd23: c = 15'd14406;
      6'd24: c = 15'd15156;
      6'd25: c = 15'd15901;
      6'd26: c = 15'd16639;
      6'd27: c = 15'd17371;
      6'd28: c = 15'd18098;
      6'd29: c = 15'd18818;
      6'd30: c = 15'd19533;
      6'd31: c = 15'd20242;
      6'd32: c = 15'd20945;
      6'd33: c = 15'd21642;
      6'd34: c = 15'd22333;
      6'd35: c = 15'd23018;
      6'd36: c = 15'd23697;
      6'd37: c = 15'd24370;
      default: c = 15'h7FFF;
    endcase
    return c;
  endfunction

  // temperature of each table point in whole degrees
  function automatic deg_t rom_deg(input idx_t i);
    deg_t d;
    unique case (i)
      6'd0:  d = -11'sd30;
      6'd1:  d = -11'sd20;
      6'd2:  d = -11'sd10;
      6'd3:  d = 11'sd0;
      6'd4:  d = 11'sd10;
      6'd5:  d = 11'sd20;
      6'd6:  d = 11'sd30;
      6'd7:  d = 11'sd40;
      6'd8:  d = 11'sd50;
      6'd9:  d = 11'sd60;
      6'd10: d = 11'sd70;
      6'd11: d = 11'sd80;
      6'd12: d = 11'sd90;
      6'd13: d = 11'sd100;
      6'd14: d = 11'sd110;
      6'd15: d = 11'sd120;
      6'd16: d = 11'sd130;
      6'd17: d = 11'sd140;
      6'd18: d = 11'sd150;
      6'd19: d = 11'sd160;
      6'd20: d = 11'sd170;
      6'd21: d = 11'sd180;
      6'd22: d = 11'sd190;
      6'd23: d = 11'sd200;
      6'd24: d = 11'sd225;
      6'd25: d = 11'sd250;
      6'd26: d = 11'sd275;
      6'd27: d = 11'sd300;
      6'd28: d = 11'sd325;
      6'd29: d = 11'sd350;
      6'd30: d = 11'sd375;
      6'd31: d = 11'sd400;
      6'd32: d = 11'sd425;
      6'd33: d = 11'sd450;
      6'd34: d = 11'sd475;
      6'd35: d = 11'sd500;
      6'd36: d = 11'sd525;
      6'd37: d = 11'sd550;
      default: d = 11'sd0;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

### design/rti_divider.sv
`default_nettype none
module rti_divider #(
  parameter int NUM_W = 23,
  parameter int DEN_W = 10
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] dividend,
  input  wire logic [DEN_W-1:0] divisor,
  output logic                  done,
  output logic [NUM_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] count;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] num;
  logic [DEN_W:0]   trial;
  logic             fits;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem, num[NUM_W-1]};
  assign fits  = trial >= {1'b0, den};

  // sequencing of the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        count <= CNT_W'(NUM_W);
      end else if (count != '0) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      den <= divisor;
      num <= dividend;
    end else if (count != '0) begin
      rem <= fits ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
      num <= {num[NUM_W-2:0], fits};
    end
  end

  assign quotient = num;

endmodule
`default_nettype wire

### design/rtd_table_interpolator.sv
`default_nettype none
// Converts one RTD converter read frame into a temperature in units of
// 2^-FRACTION_BITS degree C. A frame with a failed transfer, a bad control
// byte or the fault bit set goes from acceptance straight to the done state
// and gives its result word with the matching status and the last good
// temperature. A good frame takes a binary search of the table (one compare
// per cycle, up to 6 for 38 points), then a step that classifies the code
// (short and open circuits end here), the slope product, a step to start
// the divider, a bit-serial restoring divide of 15 + FRACTION_BITS steps,
// a step to take the quotient, and the load into the output register.
// s_tready is high only while no frame is in work; a finished word waits
// in the output register without holding back acceptance of the next
// frame, which then waits in the done state until that word is taken.
module rtd_table_interpolator #(
  parameter int TABLE_ENTRIES = 38,
  parameter int FRACTION_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,  // control_byte[7:0], result_word[23:8]
  input  wire logic [1:0]  s_tuser,  // bus_status[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,  // temperature[18:0], zero pad
  output logic [3:0]       m_tuser   // status[2:0], reinit_request[3]
);

  localparam int POINTS = (TABLE_ENTRIES < rti_pkg::ROM_POINTS) ?
                          TABLE_ENTRIES : rti_pkg::ROM_POINTS;
  localparam int NUM_W  = rti_pkg::PROD_W + FRACTION_BITS;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEARCH = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_LOAD   = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0]                      state;
  rti_pkg::code_t                  code;
  rti_pkg::idx_t                   lo;
  rti_pkg::idx_t                   hi;
  rti_pkg::idx_t                   mid;
  rti_pkg::idx_t                   idx0;
  logic [2:0]                      stat;
  logic                            reinit;
  logic [rti_pkg::PROD_W-1:0]      prod;
  rti_pkg::temp_t                  last_good;
  logic [7:0]                      ctrl;
  logic [15:0]                     word;
  rti_pkg::code_t                  code0;
  rti_pkg::code_t                  code1;
  rti_pkg::deg_t                   deg0;
  rti_pkg::deg_t                   deg1;
  logic [rti_pkg::SPAN_W-1:0]      span;
  logic [rti_pkg::SPAN_W-1:0]      diff;
  logic [rti_pkg::DT_W-1:0]        dt;
  logic                            div_done;
  logic [NUM_W-1:0]                quot;
  logic signed [31:0]              base_wide;
  logic [31:0]                     sum_wide;

  assign ctrl = s_tdata[7:0];
  assign word = s_tdata[23:8];
  assign s_tready = (state == ST_IDLE);

  // search midpoint
  assign mid = lo + ((hi - lo) >> 1);

  // neighboring table points around the located index
  assign idx0  = lo - 1'b1;
  assign code0 = rti_pkg::rom_code(idx0);
  assign code1 = rti_pkg::rom_code(lo);
  assign deg0  = rti_pkg::rom_deg(idx0);
  assign deg1  = rti_pkg::rom_deg(lo);
  assign span  = rti_pkg::SPAN_W'(code1 - code0);
  assign diff  = rti_pkg::SPAN_W'(code - code0);
  assign dt    = rti_pkg::DT_W'(deg1 - deg0);

  // base temperature plus the interpolated increment
  assign base_wide = 32'(deg0) <<< FRACTION_BITS;
  assign sum_wide  = 32'(base_wide) + 32'(quot);

  rti_divider #(
    .NUM_W (NUM_W),
    .DEN_W (rti_pkg::SPAN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_LOAD),
    .dividend ({prod, FRACTION_BITS'(0)}),
    .divisor  (span),
    .done     (div_done),
    .quotient (quot)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      last_good <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            code   <= word[15:1];
            lo     <= '0;
            hi     <= rti_pkg::IDX_W'(POINTS);
            reinit <= 1'b0;
            if (s_tuser == rti_pkg::BUS_BUSY) begin
              stat  <= rti_pkg::STAT_BUSY;
              state <= ST_DONE;
            end else if (s_tuser != rti_pkg::BUS_OK) begin
              stat  <= rti_pkg::STAT_TIMEOUT;
              state <= ST_DONE;
            end else if ((ctrl & rti_pkg::CTRL_MASK) != rti_pkg::CTRL_MASK || word[0]) begin
              stat   <= rti_pkg::STAT_HWERR;
              reinit <= 1'b1;
              state  <= ST_DONE;
            end else begin
              state <= ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          if (hi != lo) begin
            if (code <= rti_pkg::rom_code(mid)) begin
              hi <= mid;
            end else begin
              lo <= mid + 1'b1;
            end
          end else if (lo == '0) begin
            stat  <= rti_pkg::STAT_SHORT;
            state <= ST_DONE;
          end else if (lo >= rti_pkg::IDX_W'(POINTS)) begin
            stat  <= rti_pkg::STAT_OPEN;
            state <= ST_DONE;
          end else begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= rti_pkg::PROD_W'(dt) * rti_pkg::PROD_W'(diff);
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            last_good <= sum_wide[rti_pkg::TEMP_W-1:0];
            stat      <= rti_pkg::STAT_OK;
            state     <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {(24 - rti_pkg::TEMP_W)'(0), last_good};
      m_tuser <= {reinit, stat};
    end
  end

endmodule
`default_nettype wire
